### design/array_list_engine_assert.svh
// Assertion helpers used by the checker of this project.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array_list_engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ALE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array_list_engine: next-cycle check failed");

`endif

### design/ale_pkg.sv
`default_nettype none

package ale_pkg;

  localparam int WORD_W = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_SORT   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

### design/ale_ram.sv
`default_nettype none

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/ale_cmp.sv
`default_nettype none

module ale_cmp (
  input  wire logic signed [ale_pkg::WORD_W-1:0] a,
  input  wire logic signed [ale_pkg::WORD_W-1:0] b,
  output ale_pkg::cmp_res_t                      res
);

  always_comb begin
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

### design/array_list_engine.sv
// Bounded list of up to DEPTH signed 32-bit words with an entry count.
// Command channel: an operation (insert, delete, search, sort, read) with a
// 1-based position and a value is taken when start is high and busy is low.
// Results leave on the out_ ports, each valid for exactly one cycle under
// out_valid; the receiver cannot stall, so results are never held back.
// Every operation gives one result, except sort, which gives one result per
// entry (a single result when empty), the final one flagged by out_last.
// Operation codes five to seven are taken and dropped without a result.
// A rejected command, and a sort of an empty list, answer in the cycle
// after acceptance; a sort of a longer list streams its results in
// consecutive cycles. The timing of every operation follows from the
// single storage RAM, which does one read and one write per cycle, and
// the one shared comparator. Busy stays high until the last result is
// issued, so the next command is taken at the earliest at the edge that
// accepts the last result of the previous transaction.
// Reset empties the list at once; the words themselves are not cleared.
`default_nettype none

module array_list_engine #(
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [2:0]                           in_operation,
  input  wire logic [$clog2(DEPTH+1)-1:0]           in_position,
  input  wire logic signed [ale_pkg::WORD_W-1:0]    in_item_value,
  output logic                                      out_valid,
  output logic [1:0]                                out_status,
  output logic [$clog2(DEPTH+1)-1:0]                out_found_position,
  output logic signed [ale_pkg::WORD_W-1:0]         out_entry_value,
  output logic [$clog2(DEPTH+1)-1:0]                out_entry_count,
  output logic                                      out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int WW = ale_pkg::WORD_W;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SHIFT    = 9'b000000010,
    S_PUTV     = 9'b000000100,
    S_SRCH     = 9'b000001000,
    S_RDOUT    = 9'b000010000,
    S_SORT_GET = 9'b000100000,
    S_SORT_J   = 9'b001000000,
    S_SORT_WB  = 9'b010000000,
    S_SORT_OUT = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic              is_ins_r, is_ins_nxt;
  logic [WW-1:0]     val_r, val_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              chk_r, chk_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [WW-1:0]     cur_r, cur_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [CW-1:0]     out_fpos_r;
  logic [WW-1:0]     out_value_r;
  logic [CW-1:0]     out_count_r;
  logic              out_last_r;

  logic              emit;
  logic [1:0]        e_status;
  logic [CW-1:0]     e_fpos;
  logic [WW-1:0]     e_value;
  logic              e_last;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [WW-1:0]     rdata;

  logic [WW-1:0]     cmp_a;
  ale_pkg::cmp_res_t cmp_res;

  ale_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The comparator serves the search (equality with the key) and the sort
  // (held word greater than the word just read).
  assign cmp_a = (state_r == S_SORT_J) ? cur_r : val_r;

  ale_cmp u_cmp (
    .a   (cmp_a),
    .b   (rdata),
    .res (cmp_res)
  );

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    is_ins_nxt  = is_ins_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    rem_nxt     = rem_r;
    chk_nxt     = chk_r;
    chk_idx_nxt = chk_idx_r;
    cur_nxt     = cur_r;
    emit        = 1'b0;
    e_status    = ale_pkg::ST_OK;
    e_fpos      = '0;
    e_value     = '0;
    e_last      = 1'b1;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;

    case (state_r)
      S_IDLE: begin
        chk_nxt = 1'b0;
        if (start) begin
          case (in_operation)
            ale_pkg::OP_INSERT: begin
              if (n_r == CW'(DEPTH)) begin
                emit     = 1'b1;
                e_status = ale_pkg::ST_FULL;
              end else if ((in_position == '0) ||
                           ({1'b0, in_position} > ({1'b0, n_r} + (CW+1)'(1)))) begin
                emit     = 1'b1;
                e_status = ale_pkg::ST_BADPOS;
              end else begin
                is_ins_nxt = 1'b1;
                val_nxt    = in_item_value;
                pos_nxt    = AW'(in_position - CW'(1));
                idx_nxt    = n_r - CW'(1);
                j_nxt      = n_r;
                rem_nxt    = n_r - in_position + CW'(1);
                state_nxt  = S_SHIFT;
              end
            end
            ale_pkg::OP_DELETE: begin
              if ((in_position == '0) || (in_position > n_r)) begin
                emit     = 1'b1;
                e_status = ale_pkg::ST_BADPOS;
              end else begin
                is_ins_nxt = 1'b0;
                idx_nxt    = in_position;
                j_nxt      = in_position - CW'(1);
                rem_nxt    = n_r - in_position;
                state_nxt  = S_SHIFT;
              end
            end
            ale_pkg::OP_SEARCH: begin
              val_nxt   = in_item_value;
              idx_nxt   = '0;
              state_nxt = S_SRCH;
            end
            ale_pkg::OP_SORT: begin
              if (n_r == '0) begin
                emit = 1'b1;
              end else if (n_r == CW'(1)) begin
                idx_nxt   = '0;
                state_nxt = S_SORT_OUT;
              end else begin
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = S_SORT_GET;
              end
            end
            ale_pkg::OP_READ: begin
              if ((in_position == '0) || (in_position > n_r)) begin
                emit     = 1'b1;
                e_status = ale_pkg::ST_BADPOS;
              end else begin
                raddr     = AW'(in_position - CW'(1));
                state_nxt = S_RDOUT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Moves one word per cycle: the word read last cycle is written to
      // its new slot while the next source word is read.
      S_SHIFT: begin
        if (chk_r) begin
          we    = 1'b1;
          waddr = chk_idx_r;
          wdata = rdata;
        end
        if (rem_r != '0) begin
          raddr       = idx_r[AW-1:0];
          chk_nxt     = 1'b1;
          chk_idx_nxt = j_r[AW-1:0];
          rem_nxt     = rem_r - CW'(1);
          if (is_ins_r) begin
            idx_nxt = idx_r - CW'(1);
            j_nxt   = j_r - CW'(1);
          end else begin
            idx_nxt = idx_r + CW'(1);
            j_nxt   = j_r + CW'(1);
          end
        end else begin
          chk_nxt = 1'b0;
          if (!chk_r) begin
            if (is_ins_r) begin
              state_nxt = S_PUTV;
            end else begin
              n_nxt     = n_r - CW'(1);
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_PUTV: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = val_r;
        n_nxt     = n_r + CW'(1);
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_SRCH: begin
        if (chk_r && cmp_res.eq) begin
          emit      = 1'b1;
          e_fpos    = CW'(chk_idx_r) + CW'(1);
          chk_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else if (idx_r < n_r) begin
          raddr       = idx_r[AW-1:0];
          chk_nxt     = 1'b1;
          chk_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
        end else begin
          emit      = 1'b1;
          e_status  = ale_pkg::ST_NOTFOUND;
          chk_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      S_RDOUT: begin
        emit      = 1'b1;
        e_value   = rdata;
        state_nxt = S_IDLE;
      end

      // Slot i is held in cur_r while every later slot is read and compared;
      // a smaller word is swapped in and the held word goes to its slot.
      S_SORT_GET: begin
        cur_nxt   = rdata;
        j_nxt     = idx_r + CW'(1);
        chk_nxt   = 1'b0;
        state_nxt = S_SORT_J;
      end

      S_SORT_J: begin
        if (chk_r && cmp_res.gt) begin
          we      = 1'b1;
          waddr   = chk_idx_r;
          wdata   = cur_r;
          cur_nxt = rdata;
        end
        if (j_r < n_r) begin
          raddr       = j_r[AW-1:0];
          chk_nxt     = 1'b1;
          chk_idx_nxt = j_r[AW-1:0];
          j_nxt       = j_r + CW'(1);
        end else begin
          chk_nxt   = 1'b0;
          state_nxt = S_SORT_WB;
        end
      end

      S_SORT_WB: begin
        we      = 1'b1;
        waddr   = idx_r[AW-1:0];
        wdata   = cur_r;
        idx_nxt = idx_r + CW'(1);
        if (({1'b0, idx_r} + (CW+1)'(2)) < {1'b0, n_r}) begin
          raddr     = AW'(idx_r + CW'(1));
          state_nxt = S_SORT_GET;
        end else begin
          idx_nxt   = '0;
          chk_nxt   = 1'b0;
          state_nxt = S_SORT_OUT;
        end
      end

      S_SORT_OUT: begin
        if (chk_r) begin
          emit    = 1'b1;
          e_value = rdata;
          e_last  = (CW'(chk_idx_r) == (n_r - CW'(1)));
        end
        if (idx_r < n_r) begin
          raddr       = idx_r[AW-1:0];
          chk_nxt     = 1'b1;
          chk_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
        end else begin
          chk_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r  <= is_ins_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    rem_r     <= rem_nxt;
    chk_idx_r <= chk_idx_nxt;
    cur_r     <= cur_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_fpos_r   <= e_fpos;
      out_value_r  <= e_value;
      out_count_r  <= n_nxt;
      out_last_r   <= e_last;
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_entry_value    = out_value_r;
  assign out_entry_count    = out_count_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

### design/ale_chk.sv
`default_nettype none

`include "array_list_engine_assert.svh"

module ale_chk #(
  parameter int DEPTH = 16
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [2:0]                 in_operation,
  input wire logic                       out_valid,
  input wire logic [1:0]                 out_status,
  input wire logic [$clog2(DEPTH+1)-1:0] out_found_position,
  input wire logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  input wire logic                       out_last
);

  // A valid command either starts work or answers in the very next cycle.
  `ALE_ASSERT_NXT(a_cmd_answered, clk, rst_n, start && !busy && (in_operation <= ale_pkg::OP_READ), busy || out_valid)

  // A sorted run comes out in consecutive cycles until its last entry.
  `ALE_ASSERT_NXT(a_run_unbroken, clk, rst_n, out_valid && !out_last, out_valid)

  // Rejections and misses are single-result transactions.
  `ALE_ASSERT_NOW(a_fail_single, clk, rst_n, out_valid && (out_status != ale_pkg::ST_OK), out_last)

  // A search hit is reported only with an ok status.
  `ALE_ASSERT_NOW(a_hit_ok, clk, rst_n, out_valid && (out_found_position != '0), (out_status == ale_pkg::ST_OK) && out_last)

  `ALE_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, out_entry_count <= DEPTH)

endmodule

bind array_list_engine ale_chk #(
  .DEPTH (DEPTH)
) u_ale_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_operation       (in_operation),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_found_position (out_found_position),
  .out_entry_count    (out_entry_count),
  .out_last           (out_last)
);

`default_nettype wire
